// ===== design/crs_pkg.sv =====
// shared constants, control structs and saturation helper for the repulsion step block
`timescale 1ns / 1ps
package crs_pkg;

    localparam int AXES       = 7;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int CFG_W      = 31;
    localparam int H_W        = CFG_W - 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = DIFF_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int HH_W       = 2 * H_W;
    localparam int NET_W      = 39;
    localparam int HE_W       = MAG_W + H_W;
    localparam int NUM_W      = MAG_W + 2 * FRAC_BITS;
    localparam int QUO_W      = 55;
    localparam int SHORT_ITER = 34;
    localparam int LONG_ITER  = QUO_W;
    localparam int CNT_W      = 6;
    localparam int REM_W      = SUM_W + 1;
    localparam int ROOT_W     = 34;
    localparam int SOP_W      = 2 * ROOT_W;
    localparam int SREM_W     = ROOT_W + 4;
    localparam int EXT_W      = 40;
    localparam int CFG_IDX_W  = 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MASS   = 1'b1;

    localparam logic [1:0] DSEL_FORCE = 2'd0;
    localparam logic [1:0] DSEL_STEP  = 2'd1;
    localparam logic [1:0] DSEL_PROJ  = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(52428800);
    localparam logic [CFG_W-1:0] MASS_RESET   = CFG_W'(65536);

    typedef struct packed {
        logic       load_pos;
        logic       clr_net;
        logic       load_d;
        logic       load_e;
        logic       sq_en;
        logic       div_start;
        logic [1:0] div_sel;
        logic       acc_force;
        logic       apply_step;
        logic       load_he;
        logic       apply_proj;
        logic       wr_en;
        logic       wr_pos;
    } lane_ctl_t;

    typedef struct packed {
        logic sum1_en;
        logic sum2_en;
        logic sqrt_start;
    } merge_ctl_t;

    typedef struct packed {
        logic sum_zero;
        logic gt;
        logic sqrt_busy;
    } merge_sts_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(2147483647);
        lo = -EXT_W'(2147483647) - EXT_W'(1);
        if (v > hi)
            return COORD_W'(hi);
        else if (v < lo)
            return COORD_W'(lo);
        else
            return COORD_W'(v);
    endfunction

endpackage

// ===== design/crs_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module crs_div
    import crs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             long_run,
    input  logic [NUM_W-1:0] num,
    input  logic [SUM_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quot
);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [REM_W-1:0] rem_reg;
    logic [SUM_W-1:0] den_reg;
    logic [QUO_W-1:0] q_reg;
    logic [REM_W-1:0] rem_shift;
    logic             ge;

    assign rem_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= long_run ? CNT_W'(LONG_ITER) : CNT_W'(SHORT_ITER);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // the remainder starts with the bits above the quotient range
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            q_reg   <= '0;
            if (long_run)
            begin
                rem_reg <= REM_W'(num[NUM_W-1:LONG_ITER]);
                num_reg <= {num[LONG_ITER-1:0], {(NUM_W-LONG_ITER){1'b0}}};
            end
            else
            begin
                rem_reg <= REM_W'(num[NUM_W-1:SHORT_ITER]);
                num_reg <= {num[SHORT_ITER-1:0], {(NUM_W-SHORT_ITER){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_shift - {1'b0, den_reg} : rem_shift;
            q_reg   <= {q_reg[QUO_W-2:0], ge};
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// ===== design/crs_lane.sv =====
// one axis lane: coordinate memory, difference, square, divider and accumulator
`timescale 1ns / 1ps
module crs_lane
    import crs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lane_ctl_t                 ctl,
    input  logic [IDX_W-1:0]          rd_addr,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic signed [COORD_W-1:0] coord_in,
    input  logic [H_W-1:0]            h,
    input  logic [SUM_W-1:0]          den,
    output logic signed [COORD_W-1:0] pos,
    output logic [SQ_W-1:0]           sq,
    output logic                      div_busy
);

    logic signed [COORD_W-1:0] mem [MAX_POINTS];
    logic signed [COORD_W-1:0] rd_data_reg;
    logic signed [COORD_W-1:0] pos_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic signed [NET_W-1:0]   net_reg;
    logic [HE_W-1:0]           he_reg;
    logic [MAG_W-1:0]          diff_mag;
    logic [NET_W-1:0]          net_mag;
    logic [NUM_W-1:0]          div_num;
    logic [QUO_W-1:0]          div_q;
    logic signed [NET_W-1:0]   force_term;
    logic [33:0]               dv;
    logic [33:0]               pq;
    logic signed [EXT_W-1:0]   step_sum;
    logic signed [EXT_W-1:0]   proj_sum;

    localparam logic [QUO_W-1:0] STEP_LIM = QUO_W'(1) << 33;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= ctl.wr_pos ? pos_reg : coord_in;
        rd_data_reg <= mem[rd_addr];
    end

    assign diff_mag = diff_reg[DIFF_W-1] ? MAG_W'(-diff_reg) : MAG_W'(diff_reg);
    assign net_mag  = net_reg[NET_W-1] ? NET_W'(-net_reg) : NET_W'(net_reg);

    always_comb
    begin
        unique case (ctl.div_sel)
            DSEL_FORCE: div_num = NUM_W'({diff_mag, {(2 * FRAC_BITS){1'b0}}});
            DSEL_STEP:  div_num = NUM_W'({net_mag, {FRAC_BITS{1'b0}}});
            DSEL_PROJ:  div_num = NUM_W'(he_reg);
            default:    div_num = '0;
        endcase
    end

    crs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .long_run (ctl.div_sel == DSEL_STEP),
        .num      (div_num),
        .den      (den),
        .busy     (div_busy),
        .quot     (div_q)
    );

    assign force_term = $signed({{(NET_W-33){1'b0}}, div_q[32:0]});
    assign dv         = (div_q > STEP_LIM) ? STEP_LIM[33:0] : div_q[33:0];
    assign pq         = div_q[33:0];
    assign step_sum   = EXT_W'(pos_reg) + (net_reg[NET_W-1] ? -$signed({6'b0, dv})
                                                            : $signed({6'b0, dv}));
    assign proj_sum   = $signed({{(EXT_W-H_W){1'b0}}, h})
                        + (diff_reg[DIFF_W-1] ? $signed({6'b0, pq}) : -$signed({6'b0, pq}));

    always_ff @(posedge clk)
    begin
        if (ctl.load_pos)
            pos_reg <= rd_data_reg;
        else if (ctl.apply_step)
            pos_reg <= sat32(step_sum);
        else if (ctl.apply_proj)
            pos_reg <= sat32(proj_sum);

        if (ctl.load_d)
            diff_reg <= DIFF_W'(rd_data_reg) - DIFF_W'(pos_reg);
        else if (ctl.load_e)
            diff_reg <= $signed({{(DIFF_W-H_W){1'b0}}, h}) - DIFF_W'(pos_reg);

        if (ctl.sq_en)
            sq_reg <= SQ_W'(diff_mag) * SQ_W'(diff_mag);

        // repulsion pushes away from the other point
        if (ctl.clr_net)
            net_reg <= '0;
        else if (ctl.acc_force)
            net_reg <= diff_reg[DIFF_W-1] ? net_reg + force_term : net_reg - force_term;

        if (ctl.load_he)
            he_reg <= HE_W'(diff_mag) * HE_W'(h);
    end

    assign pos = pos_reg;
    assign sq  = sq_reg;

endmodule

// ===== design/crs_merge.sv =====
// merging stage: sum of squares over the lanes, radius compare, square root
`timescale 1ns / 1ps
module crs_merge
    import crs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  merge_ctl_t        ctl,
    input  logic [SQ_W-1:0]   sq [AXES],
    input  logic [H_W-1:0]    h,
    output logic [SUM_W-1:0]  sum,
    output logic [ROOT_W-1:0] root_len,
    output merge_sts_t        sts
);

    logic [SUM_W-1:0]  part_reg [4];
    logic [SUM_W-1:0]  sum_reg;
    logic [HH_W-1:0]   hh_reg;
    logic              sq_busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SOP_W-1:0]  op_reg;
    logic [SREM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] res_reg;
    logic [SREM_W-1:0] rem_shift;
    logic [SREM_W-1:0] trial;
    logic              ge;

    always_ff @(posedge clk)
    begin
        if (ctl.sum1_en)
        begin
            part_reg[0] <= SUM_W'(sq[0]) + SUM_W'(sq[1]);
            part_reg[1] <= SUM_W'(sq[2]) + SUM_W'(sq[3]);
            part_reg[2] <= SUM_W'(sq[4]) + SUM_W'(sq[5]);
            part_reg[3] <= SUM_W'(sq[6]);
        end
        if (ctl.sum2_en)
            sum_reg <= (part_reg[0] + part_reg[1]) + (part_reg[2] + part_reg[3]);
        hh_reg <= HH_W'(h) * HH_W'(h);
    end

    // digit-by-digit root, two operand bits per cycle
    assign rem_shift = {rem_reg[SREM_W-3:0], op_reg[SOP_W-1:SOP_W-2]};
    assign trial     = SREM_W'({res_reg, 2'b01});
    assign ge        = rem_shift >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (ctl.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
            cnt_reg     <= CNT_W'(ROOT_W);
        end
        else if (sq_busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sqrt_start)
        begin
            op_reg  <= SOP_W'(sum_reg);
            rem_reg <= '0;
            res_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            rem_reg <= ge ? rem_shift - trial : rem_shift;
            res_reg <= {res_reg[ROOT_W-2:0], ge};
            op_reg  <= {op_reg[SOP_W-3:0], 2'b00};
        end
    end

    assign sum           = sum_reg;
    assign root_len      = res_reg;
    assign sts.sum_zero  = (sum_reg == '0);
    assign sts.gt        = sum_reg > SUM_W'(hh_reg);
    assign sts.sqrt_busy = sq_busy_reg;

endmodule

// ===== design/charge_repulsion_step.sv =====
// top level: command port, point sequencer, seven axis lanes and the merging stage
// load: taken in the accept cycle, busy never rises, no result
// move: busy for the slot scan, one pair per other distinct valid point and the step
//   division, longer when pulled back onto the sphere; pairs are bound by the force division
// move of an invalid point: dropped in the accept cycle, no result
// reset clears the valid map and control; config holds its reset values
// one done strobe per effective move, in the first idle cycle; the receiver cannot stall
`timescale 1ns / 1ps
module charge_repulsion_step
    import crs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [IDX_W-1:0]            point_index,
    input  logic signed [COORD_W-1:0]   coord_0,
    input  logic signed [COORD_W-1:0]   coord_1,
    input  logic signed [COORD_W-1:0]   coord_2,
    input  logic signed [COORD_W-1:0]   coord_3,
    input  logic signed [COORD_W-1:0]   coord_4,
    input  logic signed [COORD_W-1:0]   coord_5,
    input  logic signed [COORD_W-1:0]   coord_6,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic                        done,
    output logic [IDX_W-1:0]            moved_index,
    output logic signed [COORD_W-1:0]   new_0,
    output logic signed [COORD_W-1:0]   new_1,
    output logic signed [COORD_W-1:0]   new_2,
    output logic signed [COORD_W-1:0]   new_3,
    output logic signed [COORD_W-1:0]   new_4,
    output logic signed [COORD_W-1:0]   new_5,
    output logic signed [COORD_W-1:0]   new_6,
    output logic                        projected
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SELF = 4'd1;
    localparam logic [3:0] ST_SCAN = 4'd2;
    localparam logic [3:0] ST_DIFF = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_SUM1 = 4'd5;
    localparam logic [3:0] ST_SUM2 = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_FDIV = 4'd8;
    localparam logic [3:0] ST_STEP = 4'd9;
    localparam logic [3:0] ST_SDIV = 4'd10;
    localparam logic [3:0] ST_EVAL = 4'd11;
    localparam logic [3:0] ST_SQRT = 4'd12;
    localparam logic [3:0] ST_PDIV = 4'd13;
    localparam logic [3:0] ST_WB   = 4'd14;

    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic                  phase_reg, phase_next;
    logic                  proj_reg, proj_next;
    logic                  done_reg, done_next;
    logic [MAX_POINTS-1:0] valid_reg, valid_next;
    logic [CFG_W-1:0]      window_reg;
    logic [CFG_W-1:0]      mass_reg;

    lane_ctl_t             lctl;
    merge_ctl_t            mctl;
    merge_sts_t            msts;
    logic                  accept;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [H_W-1:0]        h;
    logic [SUM_W-1:0]      den;
    logic [SUM_W-1:0]      sum;
    logic [ROOT_W-1:0]     root_len;
    logic signed [COORD_W-1:0] coord_arr [AXES];
    logic signed [COORD_W-1:0] pos_arr [AXES];
    logic [SQ_W-1:0]       sq_arr [AXES];
    logic [AXES-1:0]       div_busy_arr;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign h         = window_reg[CFG_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            mass_reg   <= MASS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW: window_reg <= cfg_data;
                REG_MASS:   mass_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign coord_arr[0] = coord_0;
    assign coord_arr[1] = coord_1;
    assign coord_arr[2] = coord_2;
    assign coord_arr[3] = coord_3;
    assign coord_arr[4] = coord_4;
    assign coord_arr[5] = coord_5;
    assign coord_arr[6] = coord_6;

    assign rd_addr = (state_reg == ST_IDLE) ? point_index : j_reg;
    assign wr_addr = (state_reg == ST_IDLE) ? point_index : idx_reg;

    always_comb
    begin
        unique case (lctl.div_sel)
            DSEL_FORCE: den = sum;
            DSEL_STEP:  den = (mass_reg == '0) ? SUM_W'(1) : SUM_W'(mass_reg);
            DSEL_PROJ:  den = SUM_W'(root_len);
            default:    den = SUM_W'(1);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        phase_next = phase_reg;
        proj_next  = proj_reg;
        done_next  = 1'b0;
        valid_next = valid_reg;
        lctl       = '0;
        mctl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        lctl.wr_en           = 1'b1;
                        valid_next[point_index] = 1'b1;
                    end
                    else if (valid_reg[point_index])
                    begin
                        idx_next   = point_index;
                        state_next = ST_SELF;
                    end
                end
            end
            ST_SELF:
            begin
                lctl.load_pos = 1'b1;
                lctl.clr_net  = 1'b1;
                j_next        = '0;
                phase_next    = 1'b0;
                proj_next     = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (valid_reg[j_reg] && (j_reg != idx_reg))
                    state_next = ST_DIFF;
                else if (j_reg == IDX_W'(MAX_POINTS - 1))
                    state_next = ST_STEP;
                else
                    j_next = j_reg + 1'b1;
            end
            ST_DIFF:
            begin
                lctl.load_d = 1'b1;
                state_next  = ST_SQ;
            end
            ST_SQ:
            begin
                lctl.sq_en = 1'b1;
                state_next = ST_SUM1;
            end
            ST_SUM1:
            begin
                mctl.sum1_en = 1'b1;
                state_next   = ST_SUM2;
            end
            ST_SUM2:
            begin
                mctl.sum2_en = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                if (phase_reg)
                begin
                    if (msts.gt)
                    begin
                        mctl.sqrt_start = 1'b1;
                        state_next      = ST_SQRT;
                    end
                    else
                        state_next = ST_WB;
                end
                else if (!msts.sum_zero)
                begin
                    lctl.div_start = 1'b1;
                    lctl.div_sel   = DSEL_FORCE;
                    state_next     = ST_FDIV;
                end
                else if (j_reg == IDX_W'(MAX_POINTS - 1))
                    state_next = ST_STEP;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_FDIV:
            begin
                lctl.div_sel = DSEL_FORCE;
                if (!div_busy_arr[0])
                begin
                    lctl.acc_force = 1'b1;
                    if (j_reg == IDX_W'(MAX_POINTS - 1))
                        state_next = ST_STEP;
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_STEP:
            begin
                lctl.div_start = 1'b1;
                lctl.div_sel   = DSEL_STEP;
                state_next     = ST_SDIV;
            end
            ST_SDIV:
            begin
                lctl.div_sel = DSEL_STEP;
                if (!div_busy_arr[0])
                begin
                    lctl.apply_step = 1'b1;
                    state_next      = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                lctl.load_e = 1'b1;
                phase_next  = 1'b1;
                state_next  = ST_SQ;
            end
            ST_SQRT:
            begin
                // h * e does not depend on the root, so it is formed meanwhile
                lctl.load_he = 1'b1;
                lctl.div_sel = DSEL_PROJ;
                if (!msts.sqrt_busy)
                begin
                    lctl.div_start = 1'b1;
                    state_next     = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                lctl.div_sel = DSEL_PROJ;
                if (!div_busy_arr[0])
                begin
                    lctl.apply_proj = 1'b1;
                    proj_next       = 1'b1;
                    state_next      = ST_WB;
                end
            end
            ST_WB:
            begin
                lctl.wr_en  = 1'b1;
                lctl.wr_pos = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            j_reg     <= '0;
            phase_reg <= 1'b0;
            proj_reg  <= 1'b0;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            j_reg     <= j_next;
            phase_reg <= phase_next;
            proj_reg  <= proj_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    for (genvar k = 0; k < AXES; k++)
    begin : g_lane
        crs_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (lctl),
            .rd_addr  (rd_addr),
            .wr_addr  (wr_addr),
            .coord_in (coord_arr[k]),
            .h        (h),
            .den      (den),
            .pos      (pos_arr[k]),
            .sq       (sq_arr[k]),
            .div_busy (div_busy_arr[k])
        );
    end

    crs_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mctl),
        .sq       (sq_arr),
        .h        (h),
        .sum      (sum),
        .root_len (root_len),
        .sts      (msts)
    );

    assign done        = done_reg;
    assign moved_index = idx_reg;
    assign projected   = proj_reg;
    assign new_0       = pos_arr[0];
    assign new_1       = pos_arr[1];
    assign new_2       = pos_arr[2];
    assign new_3       = pos_arr[3];
    assign new_4       = pos_arr[4];
    assign new_5       = pos_arr[5];
    assign new_6       = pos_arr[6];

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a move is in progress");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_LOAD) |=> !busy)
        else $error("load transaction left the block busy");

    a_wb_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |=> done)
        else $error("write-back without result strobe");

    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> valid_reg[moved_index])
        else $error("result for a point that is not valid");

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (div_busy_arr == '0) || (div_busy_arr == {AXES{1'b1}}))
        else $error("lane dividers out of step");

endmodule
